// ----- src/dpp_pkg.sv -----
package dpp_pkg;

  localparam int DIV_STAGES  = 8;
  localparam int SCALE_QW    = 32;
  localparam int NORM_QW     = 16;
  localparam int SCALE_ITERS = SCALE_QW / DIV_STAGES;
  localparam int NORM_ITERS  = NORM_QW / DIV_STAGES;

  localparam logic signed [31:0] SORT_Z_BIAS   = 32'sd0;
  localparam logic [16:0]        NORM_ONE      = 17'd65536;
  localparam logic [24:0]        MAX_SCALE_RST = 25'd16777216;
  localparam logic [31:0]        FAR_DEPTH_RST = 32'd65536;

  typedef enum logic [2:0] {
    REG_FOCUS_Z,
    REG_PERSP_GAIN,
    REG_MIN_SCALE,
    REG_MAX_SCALE,
    REG_NEAR_DEPTH,
    REG_FAR_DEPTH,
    REG_Y_SHIFT,
    REG_X_SKEW
  } reg_idx_t;

  // per-item data carried alongside the dividers
  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [32:0] rx;
    logic [32:0] ry;
    logic [31:0] osx;
    logic [31:0] osy;
    logic [63:0] skew_hi;
    logic [63:0] skew_lo;
    logic        skew_neg;
    logic [48:0] dzy;
    logic [47:0] keyz;
    logic        s_max;
    logic        s_min;
    logic        s_zero;
    logic        nd_zero;
    logic        nd_one;
  } side_t;

  function automatic logic [31:0] sat32(logic signed [67:0] v);
    logic [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/dpp_in_if.sv -----
interface dpp_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] depth_z;
  logic signed [31:0] camera_x;
  logic signed [31:0] camera_y;
  logic signed [31:0] object_scale_x;
  logic signed [31:0] object_scale_y;

  modport source (output valid, world_x, world_y, depth_z, camera_x, camera_y,
                  object_scale_x, object_scale_y, input ready);
  modport sink (input valid, world_x, world_y, depth_z, camera_x, camera_y,
                object_scale_x, object_scale_y, output ready);
endinterface

// ----- src/dpp_out_if.sv -----
interface dpp_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] projected_x;
  logic signed [31:0] projected_y;
  logic [24:0]        proj_scale;
  logic [16:0]        norm_depth;
  logic signed [31:0] sort_key;
  logic signed [31:0] final_scale_x;
  logic signed [31:0] final_scale_y;

  modport source (output valid, projected_x, projected_y, proj_scale, norm_depth,
                  sort_key, final_scale_x, final_scale_y, input ready);
  modport sink (input valid, projected_x, projected_y, proj_scale, norm_depth,
                sort_key, final_scale_x, final_scale_y, output ready);
endinterface

// ----- src/depth_perspective_projector.sv -----
// Depth perspective projector, Q16.16 fixed point.
// item: one point beat per cycle (world x/y, depth, camera x/y, object scales).
// result: projected x/y, clamped projection scale, normalized depth, sort key
// and object scales times projection scale, saturated to 32 bits signed.
// Registers are written through the APB port at byte address 4*index and read
// back the same way; write them only while no beat is in flight.
// Throughput: one beat per cycle unless the receiver stalls. Each accepted beat
// passes three front stages (differences, products, denominator and skew
// partial products), eight divider stages (four quotient bits of the scale and
// two of the normalized depth per stage), then clamp, multiply, sum and
// saturate.
// The whole pipeline advances when the result register is empty or taken;
// while the receiver stalls, item.ready is low and every stage holds.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
module depth_perspective_projector (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dpp_in_if.sink      item,
  dpp_out_if.source   result
);

  logic signed [31:0] focus_z;
  logic signed [31:0] perspective_gain;
  logic [24:0]        min_scale;
  logic [24:0]        max_scale;
  logic signed [31:0] near_depth;
  logic signed [31:0] far_depth;
  logic signed [31:0] y_shift_per_depth;
  logic signed [31:0] x_skew_per_depth;

  dpp_pkg::reg_idx_t  ridx;
  logic               wr;

  assign pready = 1'b1;
  assign ridx   = dpp_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_z           <= '0;
      perspective_gain  <= '0;
      min_scale         <= '0;
      max_scale         <= dpp_pkg::MAX_SCALE_RST;
      near_depth        <= '0;
      far_depth         <= dpp_pkg::FAR_DEPTH_RST;
      y_shift_per_depth <= '0;
      x_skew_per_depth  <= '0;
    end else if (wr) begin
      case (ridx)
        dpp_pkg::REG_FOCUS_Z:    focus_z           <= pwdata;
        dpp_pkg::REG_PERSP_GAIN: perspective_gain  <= pwdata;
        dpp_pkg::REG_MIN_SCALE:  min_scale         <= pwdata[24:0];
        dpp_pkg::REG_MAX_SCALE:  max_scale         <= pwdata[24:0];
        dpp_pkg::REG_NEAR_DEPTH: near_depth        <= pwdata;
        dpp_pkg::REG_FAR_DEPTH:  far_depth         <= pwdata;
        dpp_pkg::REG_Y_SHIFT:    y_shift_per_depth <= pwdata;
        dpp_pkg::REG_X_SKEW:     x_skew_per_depth  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      dpp_pkg::REG_FOCUS_Z:    prdata = focus_z;
      dpp_pkg::REG_PERSP_GAIN: prdata = perspective_gain;
      dpp_pkg::REG_MIN_SCALE:  prdata = {7'd0, min_scale};
      dpp_pkg::REG_MAX_SCALE:  prdata = {7'd0, max_scale};
      dpp_pkg::REG_NEAR_DEPTH: prdata = near_depth;
      dpp_pkg::REG_FAR_DEPTH:  prdata = far_depth;
      dpp_pkg::REG_Y_SHIFT:    prdata = y_shift_per_depth;
      dpp_pkg::REG_X_SKEW:     prdata = x_skew_per_depth;
      default:                 prdata = '0;
    endcase
  end

  function automatic logic [31:0] mag33(logic [32:0] v);
    logic [32:0] t;
    t = v[32] ? (~v + 33'd1) : v;
    return t[31:0];
  endfunction

  logic ce;
  assign ce         = !result.valid || result.ready;
  assign item.ready = ce;

  // stage 1: differences
  logic               v1;
  logic signed [32:0] s1_dz, s1_rx, s1_ry, s1_num, s1_den;
  logic signed [31:0] s1_cx, s1_cy, s1_osx, s1_osy, s1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_dz  <= 33'(item.depth_z) - 33'(focus_z);
      s1_rx  <= 33'(item.world_x) - 33'(item.camera_x);
      s1_ry  <= 33'(item.world_y) - 33'(item.camera_y);
      s1_num <= 33'(item.depth_z) - 33'(near_depth);
      s1_den <= 33'(far_depth) - 33'(near_depth);
      s1_cx  <= item.camera_x;
      s1_cy  <= item.camera_y;
      s1_osx <= item.object_scale_x;
      s1_osy <= item.object_scale_y;
      s1_z   <= item.depth_z;
    end
  end

  // stage 2: products of depth
  logic               v2;
  logic signed [64:0] s2_gp, s2_dzy;
  logic signed [63:0] s2_keyz;
  logic [63:0]        s2_a;
  logic               s2_skew_neg, s2_nd_zero;
  logic [31:0]        s2_mnum, s2_mden;
  logic signed [31:0] s2_cx, s2_cy, s2_osx, s2_osy;
  logic signed [32:0] s2_rx, s2_ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_gp       <= 65'(s1_dz) * 65'(perspective_gain);
      s2_dzy      <= 65'(s1_dz) * 65'(y_shift_per_depth);
      s2_keyz     <= 64'(s1_z) * 64'(dpp_pkg::SORT_Z_BIAS);
      s2_a        <= 64'(mag33(s1_dz)) * 64'(mag33(s1_rx));
      s2_skew_neg <= s1_dz[32] ^ s1_rx[32] ^ x_skew_per_depth[31];
      s2_nd_zero  <= (s1_den == '0) || (s1_num == '0) || (s1_num[32] != s1_den[32]);
      s2_mnum     <= mag33(s1_num);
      s2_mden     <= mag33(s1_den);
      s2_cx       <= s1_cx;
      s2_cy       <= s1_cy;
      s2_osx      <= s1_osx;
      s2_osy      <= s1_osy;
      s2_rx       <= s1_rx;
      s2_ry       <= s1_ry;
    end
  end

  // stage 3: denominator, skew partial products
  logic               v3;
  logic signed [49:0] d_c;
  logic [31:0]        m_skew;
  dpp_pkg::side_t     s3_side;
  logic [32:0]        s3_d;
  logic [31:0]        s3_mnum, s3_mden;

  assign d_c    = 50'(signed'(s2_gp[64:16])) + 50'sd65536;
  assign m_skew = x_skew_per_depth[31] ? (~x_skew_per_depth + 32'd1) : x_skew_per_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_d              <= d_c[32:0];
      s3_mnum           <= s2_mnum;
      s3_mden           <= s2_mden;
      s3_side.cx        <= s2_cx;
      s3_side.cy        <= s2_cy;
      s3_side.rx        <= s2_rx;
      s3_side.ry        <= s2_ry;
      s3_side.osx       <= s2_osx;
      s3_side.osy       <= s2_osy;
      s3_side.skew_hi   <= 64'(s2_a[63:32]) * 64'(m_skew);
      s3_side.skew_lo   <= 64'(s2_a[31:0]) * 64'(m_skew);
      s3_side.skew_neg  <= s2_skew_neg;
      s3_side.dzy       <= s2_dzy[64:16];
      s3_side.keyz      <= s2_keyz[63:16];
      s3_side.s_max     <= (d_c == 50'sd0) || (d_c == 50'sd1);
      s3_side.s_min     <= d_c[49];
      s3_side.s_zero    <= d_c > 50'sd4294967296;
      s3_side.nd_zero   <= s2_nd_zero;
      s3_side.nd_one    <= s2_mnum >= s2_mden;
    end
  end

  // dividers
  logic           dv;
  logic [31:0]    dq_s;
  logic [15:0]    dq_n;
  dpp_pkg::side_t ds;

  dpp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v3),
    .scale_d   (s3_d),
    .norm_r    (s3_mnum),
    .norm_d    (s3_mden),
    .side      (s3_side),
    .out_valid (dv),
    .scale_q   (dq_s),
    .norm_q    (dq_n),
    .out_side  (ds)
  );

  // P1: clamp, normalized depth, skew term
  logic [31:0]        s_raw;
  logic [24:0]        sc_c;
  logic [16:0]        nd_c;
  logic [63:0]        sq_c;
  logic [65:0]        sqx;
  logic               rem_c;
  logic               vp1;
  logic [24:0]        p1_sc;
  logic [16:0]        p1_nd;
  logic signed [65:0] p1_term;
  logic signed [31:0] p1_cx, p1_cy, p1_osx, p1_osy;
  logic signed [32:0] p1_rx, p1_ry;
  logic signed [48:0] p1_dzy;
  logic signed [47:0] p1_keyz;

  always_comb begin
    s_raw = ds.s_zero ? 32'd0 : dq_s;
    if (ds.s_max) begin
      sc_c = max_scale;
    end else if (ds.s_min) begin
      sc_c = min_scale;
    end else if (s_raw < {7'd0, min_scale}) begin
      sc_c = min_scale;
    end else if (s_raw > {7'd0, max_scale}) begin
      sc_c = max_scale;
    end else begin
      sc_c = s_raw[24:0];
    end
    if (ds.nd_zero) begin
      nd_c = '0;
    end else if (ds.nd_one) begin
      nd_c = dpp_pkg::NORM_ONE;
    end else begin
      nd_c = {1'b0, dq_n};
    end
    sq_c  = ds.skew_hi + {32'd0, ds.skew_lo[63:32]};
    rem_c = |ds.skew_lo[31:0];
    sqx   = {2'b00, sq_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
    end else if (ce) begin
      vp1 <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_sc   <= sc_c;
      p1_nd   <= nd_c;
      p1_term <= ds.skew_neg ? (~sqx + 66'd1 - {65'd0, rem_c}) : sqx;
      p1_cx   <= ds.cx;
      p1_cy   <= ds.cy;
      p1_osx  <= ds.osx;
      p1_osy  <= ds.osy;
      p1_rx   <= ds.rx;
      p1_ry   <= ds.ry;
      p1_dzy  <= ds.dzy;
      p1_keyz <= ds.keyz;
    end
  end

  // P2: products with the scale
  logic signed [25:0] s_sgn;
  logic               vp2;
  logic signed [58:0] p2_prx, p2_pry;
  logic signed [57:0] p2_pox, p2_poy;
  logic [24:0]        p2_sc;
  logic [16:0]        p2_nd;
  logic signed [65:0] p2_term;
  logic signed [31:0] p2_cx, p2_cy;
  logic signed [48:0] p2_dzy;
  logic signed [47:0] p2_keyz;

  assign s_sgn = signed'({1'b0, p1_sc});

  always_ff @(posedge clk) begin
    if (rst) begin
      vp2 <= 1'b0;
    end else if (ce) begin
      vp2 <= vp1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p2_prx  <= 59'(p1_rx) * 59'(s_sgn);
      p2_pry  <= 59'(p1_ry) * 59'(s_sgn);
      p2_pox  <= 58'(p1_osx) * 58'(s_sgn);
      p2_poy  <= 58'(p1_osy) * 58'(s_sgn);
      p2_sc   <= p1_sc;
      p2_nd   <= p1_nd;
      p2_term <= p1_term;
      p2_cx   <= p1_cx;
      p2_cy   <= p1_cy;
      p2_dzy  <= p1_dzy;
      p2_keyz <= p1_keyz;
    end
  end

  // P3: sums
  logic               vp3;
  logic signed [67:0] p3_px, p3_py;
  logic signed [41:0] p3_fx, p3_fy;
  logic signed [47:0] p3_keyz;
  logic [24:0]        p3_sc;
  logic [16:0]        p3_nd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp3 <= 1'b0;
    end else if (ce) begin
      vp3 <= vp2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p3_px   <= 68'(p2_cx) + 68'(signed'(p2_prx[58:16])) - 68'(p2_term);
      p3_py   <= 68'(p2_cy) + 68'(signed'(p2_pry[58:16])) - 68'(p2_dzy);
      p3_fx   <= p2_pox[57:16];
      p3_fy   <= p2_poy[57:16];
      p3_keyz <= p2_keyz;
      p3_sc   <= p2_sc;
      p3_nd   <= p2_nd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ce) begin
      result.valid <= vp3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      result.projected_x   <= dpp_pkg::sat32(p3_px);
      result.projected_y   <= dpp_pkg::sat32(p3_py);
      result.proj_scale    <= p3_sc;
      result.norm_depth    <= p3_nd;
      result.sort_key      <= dpp_pkg::sat32(p3_py + 68'(p3_keyz));
      result.final_scale_x <= dpp_pkg::sat32(68'(p3_fx));
      result.final_scale_y <= dpp_pkg::sat32(68'(p3_fy));
    end
  end

endmodule

// ----- src/dpp_div.sv -----
module dpp_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_valid,
  input  logic [32:0]         scale_d,
  input  logic [31:0]         norm_r,
  input  logic [31:0]         norm_d,
  input  dpp_pkg::side_t      side,
  output logic                out_valid,
  output logic [31:0]         scale_q,
  output logic [15:0]         norm_q,
  output dpp_pkg::side_t      out_side
);

  localparam int N = dpp_pkg::DIV_STAGES;

  logic [N-1:0]   vld;
  logic [32:0]    sr [N];
  logic [32:0]    sd [N];
  logic [31:0]    sq [N];
  logic [31:0]    nr [N];
  logic [31:0]    nd [N];
  logic [15:0]    nq [N];
  dpp_pkg::side_t sb [N];

  logic [32:0]    sr_next [N];
  logic [31:0]    sq_next [N];
  logic [31:0]    nr_next [N];
  logic [15:0]    nq_next [N];

  // restoring steps, zeros shifted in
  function automatic logic [64:0] scale_step(logic [32:0] r, logic [31:0] q, logic [32:0] d);
    logic [33:0] t;
    logic [32:0] rr;
    logic [31:0] qq;
    rr = r;
    qq = q;
    for (int k = 0; k < dpp_pkg::SCALE_ITERS; k++) begin
      t = {rr, 1'b0};
      if (t >= {1'b0, d}) begin
        t  = t - {1'b0, d};
        qq = {qq[30:0], 1'b1};
      end else begin
        qq = {qq[30:0], 1'b0};
      end
      rr = t[32:0];
    end
    return {rr, qq};
  endfunction

  function automatic logic [47:0] norm_step(logic [31:0] r, logic [15:0] q, logic [31:0] d);
    logic [32:0] t;
    logic [31:0] rr;
    logic [15:0] qq;
    rr = r;
    qq = q;
    for (int k = 0; k < dpp_pkg::NORM_ITERS; k++) begin
      t = {rr, 1'b0};
      if (t >= {1'b0, d}) begin
        t  = t - {1'b0, d};
        qq = {qq[14:0], 1'b1};
      end else begin
        qq = {qq[14:0], 1'b0};
      end
      rr = t[31:0];
    end
    return {rr, qq};
  endfunction

  // 2^32 / d: top quotient bit handled outside, remainder starts at one
  always_comb begin
    {sr_next[0], sq_next[0]} = scale_step(33'd1, 32'd0, scale_d);
    {nr_next[0], nq_next[0]} = norm_step(norm_r, 16'd0, norm_d);
    for (int i = 1; i < N; i++) begin
      {sr_next[i], sq_next[i]} = scale_step(sr[i-1], sq[i-1], sd[i-1]);
      {nr_next[i], nq_next[i]} = norm_step(nr[i-1], nq[i-1], nd[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd[0] <= scale_d;
      nd[0] <= norm_d;
      sb[0] <= side;
      for (int i = 1; i < N; i++) begin
        sd[i] <= sd[i-1];
        nd[i] <= nd[i-1];
        sb[i] <= sb[i-1];
      end
      for (int i = 0; i < N; i++) begin
        sr[i] <= sr_next[i];
        sq[i] <= sq_next[i];
        nr[i] <= nr_next[i];
        nq[i] <= nq_next[i];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign scale_q   = sq[N-1];
  assign norm_q    = nq[N-1];
  assign out_side  = sb[N-1];

endmodule

// ----- src/dpp_checker.sv -----
module dpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] projected_x,
  input logic [31:0] projected_y,
  input logic [16:0] norm_depth
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(projected_x) && $stable(projected_y))
    else $error("result beat changed while stalled");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("item stalled while result taken");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("item stalled with empty result register");

  a_nd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_depth <= 17'd65536)
    else $error("normalized depth above one");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind depth_perspective_projector dpp_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .projected_x (result.projected_x),
  .projected_y (result.projected_y),
  .norm_depth  (result.norm_depth)
);
